### src/linked_block_chain_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for linked_block_chain_allocator
// Concurrent checks, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINKED_BLOCK_CHAIN_ALLOCATOR_ASSERT_SVH
`define LINKED_BLOCK_CHAIN_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LBCA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lbca check failed");
`define LBCA_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("lbca forbidden condition");
`else
`define LBCA_ASSERT(lbl, prop)
`define LBCA_NEVER(lbl, expr)
`endif
`endif

### src/lbca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbca_pkg
// Types and constants shared by the block chain allocator.
// ----------------------------------------------------------------------------
package lbca_pkg;

	localparam int FILES       = 16;
	localparam int BLOCKS      = 128;
	localparam int BLOCK_BYTES = 512;

	localparam int FW     = $clog2(FILES);
	localparam int BW     = $clog2(BLOCKS);
	localparam int LW     = BW + 1;
	localparam int OFF_W  = $clog2(BLOCK_BYTES);
	localparam int OFFS_W = 16;
	localparam int SIZE_W = 17;
	localparam int STEP_W = OFFS_W - OFF_W;
	localparam int NEED_W = SIZE_W - OFF_W + 1;
	localparam int BA_W   = BW + OFF_W;

	localparam logic [LW-1:0] LINK_FREE = {LW{1'b1}};
	localparam logic [LW-1:0] LINK_END  = {{(LW-1){1'b1}}, 1'b0};

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_RESIZE = 2'd1,
		CMD_WRITE  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SLOT  = 2'd1,
		ST_NO_BLOCK = 2'd2,
		ST_BAD      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [3:0]        file_index;
		logic [SIZE_W-1:0] size_bytes;
		logic [OFFS_W-1:0] byte_offset;
		logic [7:0]        data_byte;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot_index;
		logic [6:0] block_index;
	} out_t;

	typedef struct packed {
		logic          we;
		logic [BW-1:0] addr;
		logic [LW-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic            we;
		logic [BA_W-1:0] addr;
		logic [7:0]      data;
	} byte_wr_t;

endpackage

### src/lbca_link_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbca_link_mem
// Link table: one write and one read port, registered read, per-entry valid
// bits so that unwritten entries read as free.
// ----------------------------------------------------------------------------
module lbca_link_mem import lbca_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  link_wr_t      wr,
	input  logic [BW-1:0] raddr,
	output logic [LW-1:0] rdata
);

	logic [LW-1:0]     mem [BLOCKS];
	logic [BLOCKS-1:0] valid_q;
	logic [LW-1:0]     rdata_s1;
	logic              vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (wr.we)
				valid_q[wr.addr] <= 1'b1;
			vld_s1 <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we)
			mem[wr.addr] <= wr.data;
		rdata_s1 <= mem[raddr];
	end

	assign rdata = vld_s1 ? rdata_s1 : LINK_FREE;

endmodule

### src/lbca_byte_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbca_byte_mem
// Byte store, write-only from the block's point of view.
// ----------------------------------------------------------------------------
module lbca_byte_mem import lbca_pkg::*; (
	input  logic     clk,
	input  byte_wr_t wr
);

	logic [7:0] mem [BLOCKS*BLOCK_BYTES];

	always_ff @(posedge clk) begin
		if (wr.we)
			mem[wr.addr] <= wr.data;
	end

endmodule

### src/linked_block_chain_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_block_chain_allocator
// FAT-style file slots, block chains and byte store with one result per command.
// ----------------------------------------------------------------------------
// One command at a time; every link access goes through the link table (one
// read and one write port) with a registered read. Each command is accepted
// in S_IDLE and hands its result to the output register from S_DONE.
// Allocate adds a free-block scan of one entry per cycle. Resize walks the
// chain in S_WALK_RD and S_WALK_DAT, takes a scan and S_GROW per block added,
// then ends the chain in S_TRIM_RD and S_TRIM_END and frees each block of the
// tail in S_TRIM_DAT. Write byte walks the chain in S_WALK_RD and S_WALK_DAT
// to reach the offset, then stores the byte in S_BYTE.
// A result sits in an output register; the next command is taken while it
// waits, and that command's result holds until the register frees.
module linked_block_chain_allocator import lbca_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_SCAN     = 10'b0000000010,
		S_GROW     = 10'b0000000100,
		S_WALK_RD  = 10'b0000001000,
		S_WALK_DAT = 10'b0000010000,
		S_TRIM_RD  = 10'b0000100000,
		S_TRIM_END = 10'b0001000000,
		S_TRIM_DAT = 10'b0010000000,
		S_BYTE     = 10'b0100000000,
		S_DONE     = 10'b1000000000
	} state_t;

	state_t             state_q;
	logic [1:0]         cmd_q;
	logic [FW-1:0]      fi_q;
	logic [FW-1:0]      slot_q;
	logic [NEED_W-1:0]  need_q;
	logic [NEED_W-1:0]  have_q;
	logic [STEP_W-1:0]  steps_q;
	logic [OFF_W-1:0]   within_q;
	logic [7:0]         data_q;
	logic [BW-1:0]      blk_q;
	logic [BW-1:0]      nb_q;
	logic [BW-1:0]      cur_q;
	logic [BW-1:0]      scan_ptr_q;
	logic [BW-1:0]      addr_s1;
	logic               chk_s1;
	out_t               res_q;
	logic               out_valid_q;
	out_t               out_q;
	logic [FILES-1:0]   used_q;
	logic [BW-1:0]      first_q [FILES];

	link_wr_t           lw;
	byte_wr_t           bw;
	logic [BW-1:0]      raddr;
	logic [LW-1:0]      rd;
	logic               is_blk;
	logic               scan_hit;
	logic               slot_found;
	logic [FW-1:0]      free_slot;
	logic               fi_bad;
	logic [SIZE_W:0]    size_up;
	logic [NEED_W-1:0]  need_c;
	logic [NEED_W-1:0]  have_inc;
	logic [STEP_W-1:0]  steps_c;

	lbca_link_mem u_link (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (lw),
		.raddr  (raddr),
		.rdata  (rd)
	);

	lbca_byte_mem u_bytes (
		.clk (clk),
		.wr  (bw)
	);

	assign is_blk   = !rd[LW-1];
	assign scan_hit = (state_q == S_SCAN) && chk_s1 && (rd == LINK_FREE);
	assign have_inc = have_q + 1'b1;
	assign size_up  = {1'b0, in_data.size_bytes} + (SIZE_W+1)'(BLOCK_BYTES - 1);
	assign need_c   = (size_up[SIZE_W:OFF_W] == '0) ? NEED_W'(1)
		: NEED_W'(size_up[SIZE_W:OFF_W]);
	assign steps_c  = in_data.byte_offset[OFFS_W-1:OFF_W];
	assign fi_bad   = (int'(in_data.file_index) >= FILES) || !used_q[in_data.file_index];

	always_comb begin
		slot_found = 1'b0;
		free_slot  = '0;
		for (int i = FILES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				slot_found = 1'b1;
				free_slot  = FW'(i);
			end
		end
	end

	always_comb begin
		lw    = '0;
		raddr = blk_q;
		unique case (state_q)
			S_SCAN: begin
				raddr = scan_ptr_q;
				if (scan_hit) begin
					lw.we = 1'b1;
					if (cmd_q == CMD_ALLOC) begin
						lw.addr = addr_s1;
						lw.data = LINK_END;
					end else begin
						lw.addr = blk_q;
						lw.data = {1'b0, addr_s1};
					end
				end
			end
			S_GROW: lw = '{we: 1'b1, addr: nb_q, data: LINK_END};
			S_TRIM_END: begin
				lw    = '{we: 1'b1, addr: blk_q, data: LINK_END};
				raddr = rd[BW-1:0];
			end
			S_TRIM_DAT: begin
				lw    = '{we: 1'b1, addr: cur_q, data: LINK_FREE};
				raddr = rd[BW-1:0];
			end
			default: raddr = blk_q;
		endcase
	end

	assign bw = '{we: (state_q == S_BYTE), addr: {blk_q, within_q}, data: data_q};

	always_ff @(posedge clk) begin
		if (scan_hit && cmd_q == CMD_ALLOC)
			first_q[slot_q] <= addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			cmd_q       <= '0;
			fi_q        <= '0;
			slot_q      <= '0;
			need_q      <= '0;
			have_q      <= '0;
			steps_q     <= '0;
			within_q    <= '0;
			data_q      <= '0;
			blk_q       <= '0;
			nb_q        <= '0;
			cur_q       <= '0;
			scan_ptr_q  <= '0;
			addr_s1     <= '0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q    <= in_data.cmd;
						fi_q     <= in_data.file_index;
						within_q <= in_data.byte_offset[OFF_W-1:0];
						data_q   <= in_data.data_byte;
						need_q   <= need_c;
						have_q   <= NEED_W'(1);
						steps_q  <= steps_c;
						if (in_data.cmd == CMD_ALLOC) begin
							if (!slot_found) begin
								res_q   <= '{ST_NO_SLOT, 4'd0, 7'd0};
								state_q <= S_DONE;
							end else begin
								slot_q     <= free_slot;
								scan_ptr_q <= '0;
								chk_s1     <= 1'b0;
								state_q    <= S_SCAN;
							end
						end else if (in_data.cmd == CMD_NONE || fi_bad) begin
							res_q   <= '{ST_BAD, in_data.file_index, 7'd0};
							state_q <= S_DONE;
						end else begin
							blk_q <= first_q[in_data.file_index];
							if (in_data.cmd == CMD_RESIZE)
								state_q <= (need_c > NEED_W'(1)) ? S_WALK_RD : S_TRIM_RD;
							else
								state_q <= (steps_c == '0) ? S_BYTE : S_WALK_RD;
						end
					end
				end
				S_SCAN: begin
					scan_ptr_q <= scan_ptr_q + 1'b1;
					addr_s1    <= scan_ptr_q;
					chk_s1     <= 1'b1;
					if (scan_hit) begin
						if (cmd_q == CMD_ALLOC) begin
							used_q[slot_q] <= 1'b1;
							res_q   <= '{ST_OK, slot_q, 7'(addr_s1)};
							state_q <= S_DONE;
						end else begin
							nb_q    <= addr_s1;
							state_q <= S_GROW;
						end
					end else if (chk_s1 && addr_s1 == BW'(BLOCKS - 1)) begin
						if (cmd_q == CMD_ALLOC)
							res_q <= '{ST_NO_BLOCK, slot_q, 7'd0};
						else
							res_q <= '{ST_NO_BLOCK, fi_q, 7'(blk_q)};
						state_q <= S_DONE;
					end
				end
				S_GROW: begin
					blk_q  <= nb_q;
					have_q <= have_inc;
					if (have_inc < need_q) begin
						scan_ptr_q <= '0;
						chk_s1     <= 1'b0;
						state_q    <= S_SCAN;
					end else begin
						state_q <= S_TRIM_RD;
					end
				end
				S_WALK_RD: state_q <= S_WALK_DAT;
				S_WALK_DAT: begin
					if (cmd_q == CMD_RESIZE) begin
						if (is_blk) begin
							blk_q   <= rd[BW-1:0];
							have_q  <= have_inc;
							state_q <= (have_inc < need_q) ? S_WALK_RD : S_TRIM_RD;
						end else begin
							scan_ptr_q <= '0;
							chk_s1     <= 1'b0;
							state_q    <= S_SCAN;
						end
					end else if (!is_blk) begin
						res_q   <= '{ST_BAD, fi_q, 7'd0};
						state_q <= S_DONE;
					end else begin
						blk_q   <= rd[BW-1:0];
						steps_q <= steps_q - 1'b1;
						state_q <= (steps_q == STEP_W'(1)) ? S_BYTE : S_WALK_RD;
					end
				end
				S_TRIM_RD: state_q <= S_TRIM_END;
				S_TRIM_END, S_TRIM_DAT: begin
					cur_q <= rd[BW-1:0];
					if (is_blk) begin
						state_q <= S_TRIM_DAT;
					end else begin
						res_q   <= '{ST_OK, fi_q, 7'(blk_q)};
						state_q <= S_DONE;
					end
				end
				S_BYTE: begin
					res_q   <= '{ST_OK, fi_q, 7'(blk_q)};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`include "linked_block_chain_allocator_assert.svh"

	`LBCA_ASSERT(a_accept_leaves_idle, (in_valid && in_ready) |=> (state_q != S_IDLE))
	`LBCA_NEVER(a_trim_rw_same_entry, state_q == S_TRIM_DAT && is_blk && lw.addr == raddr)
	`LBCA_ASSERT(a_no_slot_zero, (out_valid && out_data.status == ST_NO_SLOT) |-> (out_data.slot_index == 4'd0 && out_data.block_index == 7'd0))

endmodule
